// ===== src/lane_delay_line_bank_macros.svh =====
// Assertion macros shared by the lane delay line bank checkers.
`ifndef LANE_DELAY_LINE_BANK_MACROS_SVH
`define LANE_DELAY_LINE_BANK_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LDL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LDL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is seen.
`define LDL_ASSERT_RST(label, clk, rst_n, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

// ===== src/ldl_pkg.sv =====
// Package with types, constants and helpers of the lane delay line bank.
`default_nettype none
package ldl_pkg;

  // Geometry
  localparam int LANES     = 28;
  localparam int MAX_DELAY = 128;

  localparam int LANE_W   = 5;   // lane index field width
  localparam int LPOS_W   = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int LEN_W    = 8;   // one delay length in a config register
  localparam int SLOT_W   = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int FILL_W   = $clog2(MAX_DELAY + 1);
  localparam int DEPTH    = LANES * MAX_DELAY;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W   = 8;
  localparam int WORD_W   = DATA_W + 2;
  localparam int FRAME_W  = 8;
  localparam int FRAME_MAX = (1 << FRAME_W) - 1;

  // Configuration port
  localparam int CFG_REGS  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;
  localparam int LANES_PER_REG = CFG_W / LEN_W;

  // Stream widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // Command queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAYS_A = 2'd0,
    REG_DELAYS_B = 2'd1,
    REG_DELAYS_C = 2'd2,
    REG_DELAYS_D = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  // Byte plus flags, byte in the low bits
  typedef struct packed {
    logic              padded;
    logic              error;
    logic [DATA_W-1:0] data;
  } item_t;

  // Classified push handed from the front to the back
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    item_t             item;
    logic              bypass;     // zero-length lane, no ring access
    logic              stored_ok;  // slot written since last flush
    logic              emit;       // all lanes primed, result goes out
    logic [LANE_W-1:0] lane;
    logic              last;
  } cmd_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] lim;
    lim = LEN_W'(MAX_DELAY);
    return (raw > lim) ? lim : raw;
  endfunction

endpackage
`default_nettype wire

// ===== src/ldl_ram.sv =====
// Generic single-clock RAM, one write and one registered read port, read-first.
`default_nettype none
module ldl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Old contents come out on a same-address read and write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== src/ldl_front.sv =====
// Front end: config registers, lane/frame counters, ring heads and item classification.
`default_nettype none
module ldl_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [ldl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ldl_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [ldl_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic                          in_tuser,
  input  wire logic                          q_full,
  output logic                               cmd_push,
  output ldl_pkg::cmd_t                      cmd
);

  logic [ldl_pkg::CFG_REGS-1:0][ldl_pkg::CFG_W-1:0]   cfg_r;
  logic [ldl_pkg::LANES-1:0][ldl_pkg::LEN_W-1:0]      lane_len;
  logic [ldl_pkg::LANES-1:0][ldl_pkg::SLOT_W-1:0]     head_r, head_nxt;
  logic [ldl_pkg::LANES-1:0][ldl_pkg::FILL_W-1:0]     fill_r, fill_nxt;
  logic [ldl_pkg::LPOS_W-1:0]                         lane_pos_r, lane_pos_nxt;
  logic [ldl_pkg::FRAME_W-1:0]                        frames_r, frames_nxt;

  logic                        accept, push_acc, flush_acc;
  logic [ldl_pkg::LEN_W-1:0]   len;
  logic [ldl_pkg::SLOT_W-1:0]  head, slot;
  logic [ldl_pkg::LEN_W-1:0]   slot_inc;
  logic                        all_ready, is_last;
  ldl_pkg::item_t              item;
  ldl_pkg::op_t                op;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  // Clamped delay length of every lane
  always_comb begin
    for (int l = 0; l < ldl_pkg::LANES; l++) begin
      lane_len[l] = ldl_pkg::clamp_len(
        cfg_r[l / ldl_pkg::LANES_PER_REG]
             [(l % ldl_pkg::LANES_PER_REG) * ldl_pkg::LEN_W +: ldl_pkg::LEN_W]);
    end
  end

  // Primed once frames pushed reach every lane length
  always_comb begin
    all_ready = 1'b1;
    for (int l = 0; l < ldl_pkg::LANES; l++) begin
      if (frames_r < lane_len[l]) begin
        all_ready = 1'b0;
      end
    end
  end

  // Handshake and decode
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign op        = ldl_pkg::op_t'(in_tuser);
  assign push_acc  = accept && (op == ldl_pkg::OP_PUSH);
  assign flush_acc = accept && (op == ldl_pkg::OP_FLUSH);
  assign item      = ldl_pkg::item_t'(in_tdata[ldl_pkg::WORD_W-1:0]);

  // Ring slot for the current lane; a head past a shortened length restarts
  assign len      = lane_len[lane_pos_r];
  assign head     = head_r[lane_pos_r];
  assign slot     = (ldl_pkg::LEN_W'(head) >= len) ? '0 : head;
  assign slot_inc = ldl_pkg::LEN_W'(slot) + ldl_pkg::LEN_W'(1);
  assign is_last  = (lane_pos_r == ldl_pkg::LPOS_W'(ldl_pkg::LANES - 1));

  // Command to the back end
  always_comb begin
    cmd.addr      = ldl_pkg::ADDR_W'(ldl_pkg::ADDR_W'(lane_pos_r) *
                                     ldl_pkg::ADDR_W'(ldl_pkg::MAX_DELAY))
                    + ldl_pkg::ADDR_W'(slot);
    cmd.item      = item;
    cmd.bypass    = (len == '0);
    cmd.stored_ok = (ldl_pkg::FILL_W'(slot) < fill_r[lane_pos_r]);
    cmd.emit      = all_ready;
    cmd.lane      = ldl_pkg::LANE_W'(lane_pos_r);
    cmd.last      = is_last;
  end
  assign cmd_push = push_acc;

  // Next state of counters, heads and fill marks
  always_comb begin
    lane_pos_nxt = lane_pos_r;
    frames_nxt   = frames_r;
    head_nxt     = head_r;
    fill_nxt     = fill_r;
    if (flush_acc) begin
      lane_pos_nxt = '0;
      frames_nxt   = '0;
      head_nxt     = '0;
      fill_nxt     = '0;
    end else if (push_acc) begin
      if (len != '0) begin
        head_nxt[lane_pos_r] = (slot_inc >= len) ? '0 : ldl_pkg::SLOT_W'(slot_inc);
        if (ldl_pkg::FILL_W'(slot_inc) > fill_r[lane_pos_r]) begin
          fill_nxt[lane_pos_r] = ldl_pkg::FILL_W'(slot_inc);
        end
      end
      if (is_last) begin
        lane_pos_nxt = '0;
        if (frames_r != ldl_pkg::FRAME_W'(ldl_pkg::FRAME_MAX)) begin
          frames_nxt = frames_r + ldl_pkg::FRAME_W'(1);
        end
      end else begin
        lane_pos_nxt = lane_pos_r + ldl_pkg::LPOS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_pos_r <= '0;
      frames_r   <= '0;
      head_r     <= '0;
      fill_r     <= '0;
    end else begin
      lane_pos_r <= lane_pos_nxt;
      frames_r   <= frames_nxt;
      head_r     <= head_nxt;
      fill_r     <= fill_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/ldl_queue.sv =====
// Short command queue between the front and back ends.
`default_nettype none
module ldl_queue (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire ldl_pkg::cmd_t push_cmd,
  output logic        full,
  input  wire logic   pop,
  output logic        not_empty,
  output ldl_pkg::cmd_t pop_cmd
);

  ldl_pkg::cmd_t                 slots_r [ldl_pkg::QUEUE_DEPTH];
  logic [ldl_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [ldl_pkg::QPTR_W:0]      count_r, count_nxt;

  assign full      = (count_r == (ldl_pkg::QPTR_W + 1)'(ldl_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_cmd   = slots_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (ldl_pkg::QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (ldl_pkg::QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + ldl_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + ldl_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/ldl_back.sv =====
// Back end: ring read-modify-write in the delay store and the output register.
`default_nettype none
module ldl_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_valid,
  input  wire ldl_pkg::cmd_t                   q_cmd,
  output logic                                 q_pop,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [ldl_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tlast
);

  logic                              s1_v_r;
  ldl_pkg::cmd_t                     s1_cmd_r;
  logic                              out_v_r;
  logic [ldl_pkg::OUT_TDATA_W-1:0]   out_data_r;
  logic                              out_last_r;

  logic                              out_free, s1_adv, ram_op;
  logic [ldl_pkg::WORD_W-1:0]        ram_rd;
  ldl_pkg::item_t                    word;

  // Flow control: s1 moves when the output register can take it
  assign out_free = !out_v_r || out_tready;
  assign s1_adv   = s1_v_r && out_free;
  assign q_pop    = q_valid && (!s1_v_r || s1_adv);
  assign ram_op   = q_pop && !q_cmd.bypass;

  // Delay store: old entry out, new item in, same slot
  ldl_ram #(
    .WIDTH (ldl_pkg::WORD_W),
    .DEPTH (ldl_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_op),
    .wr_addr (q_cmd.addr),
    .wr_data (q_cmd.item),
    .rd_en   (ram_op),
    .rd_addr (q_cmd.addr),
    .rd_data (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (q_pop) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_cmd_r <= q_cmd;
    end
  end

  // Unwritten slots since the last flush read as zero
  always_comb begin
    if (s1_cmd_r.bypass) begin
      word = s1_cmd_r.item;
    end else if (s1_cmd_r.stored_ok) begin
      word = ldl_pkg::item_t'(ram_rd);
    end else begin
      word = '0;
    end
  end

  // Output register; items without a result are dropped here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv && s1_cmd_r.emit) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_cmd_r.emit) begin
      out_data_r <= ldl_pkg::OUT_TDATA_W'({s1_cmd_r.lane, word});
      out_last_r <= s1_cmd_r.last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ===== src/lane_delay_line_bank.sv =====
// A push's result passes the command queue, the s1 stage and the output register.
// One item per cycle unless a full queue or low out_tready stalls; one delay-store RMW per push.
// Flush empties all rings at once through per-lane fill marks.
// Reset (rst_n low, synchronous) clears registers, counters and queue;
// the delay store itself is not swept, unwritten slots read as zero.
`default_nettype none
module lane_delay_line_bank (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration
  input  wire logic                            cfg_wr_en,
  input  wire logic [ldl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ldl_pkg::CFG_W-1:0]       cfg_data,
  // input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [ldl_pkg::IN_TDATA_W-1:0]  in_tdata,  // data_byte, error_flag, padded_flag
  input  wire logic                            in_tuser,  // operation
  // result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [ldl_pkg::OUT_TDATA_W-1:0]      out_tdata, // out_byte, out_error, out_padded,
                                                          // lane_index
  output logic                                 out_tlast  // last_of_frame
);

  ldl_pkg::cmd_t front_cmd, back_cmd;
  logic          cmd_push, q_full, q_valid, q_pop;

  ldl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .cmd_push  (cmd_push),
    .cmd       (front_cmd)
  );

  ldl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_cmd   (back_cmd)
  );

  ldl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (back_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== src/ldl_checker.sv =====
// Port-level checks of the lane delay line bank and their bind.
`default_nettype none
`include "lane_delay_line_bank_macros.svh"
module ldl_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [ldl_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                            out_tlast
);

  // Stalled result holds
  `LDL_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // Frame end marker goes with the last lane and only with it
  `LDL_ASSERT_IMP(a_last_lane, clk, rst_n, out_tvalid, (out_tdata[14:10] == 5'(ldl_pkg::LANES - 1)) == out_tlast, "tlast does not match last lane")

  // No result right out of reset
  `LDL_ASSERT_RST(a_rst_idle, clk, rst_n, !out_tvalid, "result valid after reset")

endmodule

bind lane_delay_line_bank ldl_checker u_ldl_checker (.*);
`default_nettype wire

// ===== verif/lane_delay_line_bank_tb.sv =====
// Self-checking testbench for the lane delay line bank: item streams checked against a predictor.
module lane_delay_line_bank_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES       = 8;    // covers the pipeline latency with margin
  localparam int HOLD_CYCLES        = 80;   // long receiver hold-off
  localparam int RANDOM_ITEMS       = 600;
  localparam int DEEP_FRAMES        = 3;    // partly fills the full-depth rings

  // One lane byte as it leaves the block
  typedef struct packed {
    ldl_pkg::item_t             word;
    logic [ldl_pkg::LANE_W-1:0] lane;
    logic                       last;
  } lane_byte_t;

  // Delay line predictor plus the queue of lane bytes still owed by the block
  class deinterleave_scoreboard;
    logic [ldl_pkg::CFG_W-1:0] delay_regs [ldl_pkg::CFG_REGS];
    ldl_pkg::item_t            ring [ldl_pkg::LANES][ldl_pkg::MAX_DELAY];
    int unsigned      ring_head [ldl_pkg::LANES];
    int unsigned      frames_done;
    int unsigned      next_lane;
    lane_byte_t       owed_bytes [$];
    int unsigned      mismatches, items_seen, flushes_seen, bytes_predicted, bytes_checked;
    int unsigned      reg_writes;

    function new();
      foreach (delay_regs[i]) delay_regs[i] = '0;
      clear_rings();
      mismatches      = 0;
      items_seen      = 0;
      flushes_seen    = 0;
      bytes_predicted = 0;
      bytes_checked   = 0;
      reg_writes      = 0;
    endfunction

    function void clear_rings();
      foreach (ring[l, s]) ring[l][s] = '0;
      foreach (ring_head[l]) ring_head[l] = 0;
      frames_done = 0;
      next_lane   = 0;
    endfunction

    // Clamped delay of one lane from the current registers
    function int unsigned lane_length(int unsigned lane);
      int unsigned raw;
      raw = delay_regs[lane / ldl_pkg::LANES_PER_REG]
                      [(lane % ldl_pkg::LANES_PER_REG) * ldl_pkg::LEN_W +: ldl_pkg::LEN_W];
      return (raw > ldl_pkg::MAX_DELAY) ? ldl_pkg::MAX_DELAY : raw;
    endfunction

    function void note_reg_write(ldl_pkg::reg_idx_t idx, logic [ldl_pkg::CFG_W-1:0] value);
      delay_regs[idx] = value;
      reg_writes++;
    endfunction

    // Advance the delay lines by one accepted item
    function void accept_item(ldl_pkg::op_t op, ldl_pkg::item_t word_in);
      int unsigned    lane, len, slot, longest, i;
      bit             ready;
      ldl_pkg::item_t word_out;
      lane_byte_t     owed;
      items_seen++;
      if (op == ldl_pkg::OP_FLUSH) begin
        flushes_seen++;
        clear_rings();
        return;
      end
      lane    = next_lane;
      longest = 0;
      for (i = 0; i < ldl_pkg::LANES; i++) begin
        if (lane_length(i) > longest) longest = lane_length(i);
      end
      ready = (frames_done >= longest);
      len   = lane_length(lane);
      // zero length passes straight through, otherwise swap with the ring slot
      if (len == 0) begin
        word_out = word_in;
      end else begin
        slot = ring_head[lane];
        if (slot >= len) slot = 0;
        word_out         = ring[lane][slot];
        ring[lane][slot] = word_in;
        slot++;
        ring_head[lane] = (slot >= len) ? 0 : slot;
      end
      owed.word = word_out;
      owed.lane = lane[ldl_pkg::LANE_W-1:0];
      owed.last = (lane == ldl_pkg::LANES - 1);
      if (owed.last) begin
        next_lane = 0;
        if (frames_done < ldl_pkg::FRAME_MAX) frames_done++;
      end else begin
        next_lane = lane + 1;
      end
      if (ready) begin
        owed_bytes = {owed_bytes, owed};
        bytes_predicted++;
      end
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one accepted lane byte with the oldest owed one
    function void check_result(lane_byte_t got);
      lane_byte_t want;
      if (owed_bytes.size() == 0) begin
        $error("lane byte with nothing owed: lane %0d byte %0h", got.lane, got.word.data);
        mismatches++;
        return;
      end
      want = owed_bytes.pop_front();
      bytes_checked++;
      check_field("out_byte", want.word.data, got.word.data);
      check_field("out_error", want.word.error, got.word.error);
      check_field("out_padded", want.word.padded, got.word.padded);
      check_field("lane_index", want.lane, got.lane);
      check_field("last_of_frame", want.last, got.last);
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_wr_en;
  ldl_pkg::reg_idx_t               cfg_index;
  logic [ldl_pkg::CFG_W-1:0]       cfg_data;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [ldl_pkg::IN_TDATA_W-1:0]  in_tdata;   // data_byte, error_flag, padded_flag
  logic                            in_tuser;   // operation
  logic                            out_tvalid;
  logic                            out_tready;
  logic [ldl_pkg::OUT_TDATA_W-1:0] out_tdata;  // out_byte, out_error, out_padded, lane_index
  logic                            out_tlast;  // last_of_frame

  deinterleave_scoreboard sb = new();
  int unsigned            burst_left;
  bit                     hold_request;

  lane_delay_line_bank u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Monitor: register writes, results, then accepted items
  always @(posedge clk) begin
    lane_byte_t got;
    if (rst_n) begin
      if (cfg_wr_en) sb.note_reg_write(cfg_index, cfg_data);
      if (out_tvalid && out_tready) begin
        got.word = ldl_pkg::item_t'(out_tdata[ldl_pkg::WORD_W-1:0]);
        got.lane = out_tdata[ldl_pkg::WORD_W +: ldl_pkg::LANE_W];
        got.last = out_tlast;
        sb.check_result(got);
      end
      if (in_tvalid && in_tready) begin
        sb.accept_item(ldl_pkg::op_t'(in_tuser),
                       ldl_pkg::item_t'(in_tdata[ldl_pkg::WORD_W-1:0]));
      end
    end
  end

  // Receiver: stall patterns picked at random, plus requested hold-offs
  initial begin : receiver
    int unsigned mode, left, tick, hold_left;
    out_tready = 1'b0;
    mode       = 0;
    left       = 0;
    tick       = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        tick++;
        case (mode)
          0: begin
            out_tready <= 1'b1;
          end
          1: begin
            out_tready <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_tready <= (tick % 3 == 0);
          end
          default: begin
            out_tready <= ($urandom_range(0, 7) != 0);
          end
        endcase
      end
    end
  end

  // Offer one item, in bursts with random gaps, and wait for it to be taken
  task automatic send_item(ldl_pkg::op_t op, logic [ldl_pkg::DATA_W-1:0] data,
                           logic err, logic pad);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(ldl_pkg::IN_TDATA_W - ldl_pkg::WORD_W){1'b0}}, pad, err, data};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_push();
    send_item(ldl_pkg::OP_PUSH, ldl_pkg::DATA_W'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_flush();
    send_item(ldl_pkg::OP_FLUSH, ldl_pkg::DATA_W'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Stop offering and wait until every owed lane byte is out and the pipe is quiet
  task automatic drain_block();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.owed_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(ldl_pkg::reg_idx_t idx, logic [ldl_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic program_delays(logic [ldl_pkg::CFG_W-1:0] a, logic [ldl_pkg::CFG_W-1:0] b,
                                logic [ldl_pkg::CFG_W-1:0] c, logic [ldl_pkg::CFG_W-1:0] d);
    write_reg(ldl_pkg::REG_DELAYS_A, a);
    write_reg(ldl_pkg::REG_DELAYS_B, b);
    write_reg(ldl_pkg::REG_DELAYS_C, c);
    write_reg(ldl_pkg::REG_DELAYS_D, d);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly short delays so rings prime quickly; unused lanes get any byte
  function automatic logic [ldl_pkg::CFG_W-1:0] random_delays(int unsigned first_lane,
                                                              bit all_zero);
    logic [ldl_pkg::CFG_W-1:0] v;
    int unsigned               pick, i;
    v = '0;
    for (i = 0; i < ldl_pkg::LANES_PER_REG; i++) begin
      pick = $urandom_range(0, 99);
      if (first_lane + i >= ldl_pkg::LANES) begin
        v[i*ldl_pkg::LEN_W +: ldl_pkg::LEN_W] = ldl_pkg::LEN_W'($urandom_range(0, 255));
      end else if (all_zero || pick < 50) begin
        v[i*ldl_pkg::LEN_W +: ldl_pkg::LEN_W] = '0;
      end else if (pick < 88) begin
        v[i*ldl_pkg::LEN_W +: ldl_pkg::LEN_W] = ldl_pkg::LEN_W'($urandom_range(1, 3));
      end else begin
        v[i*ldl_pkg::LEN_W +: ldl_pkg::LEN_W] = ldl_pkg::LEN_W'($urandom_range(4, 6));
      end
    end
    return v;
  endfunction

  // One random phase: new delays, optional flush, then mostly pushes
  task automatic random_phase(bit all_zero, bit restart, bit squeeze);
    int unsigned n, k;
    drain_block();
    program_delays(random_delays(0, all_zero), random_delays(8, all_zero),
                   random_delays(16, all_zero), random_delays(24, all_zero));
    if (restart) send_flush();
    n = $urandom_range(60, 200);
    for (k = 0; k < n; k++) begin
      if (squeeze && k == 20) hold_request = 1'b1;
      if (k == n / 2 && $urandom_range(0, 3) == 0) drain_block();
      if ($urandom_range(0, 49) == 0) send_flush();
      else send_push();
    end
  endtask

  // Stimulus
  initial begin : stimulus
    logic [ldl_pkg::CFG_W-1:0] regs_b, regs_c;
    int unsigned               k, base_items, phase;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = ldl_pkg::REG_DELAYS_A;
    cfg_data     = '0;
    in_tvalid    = 1'b0;
    in_tuser     = ldl_pkg::OP_PUSH;
    in_tdata     = '0;
    burst_left   = 0;
    hold_request = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset delays are all zero: every push passes straight through
    send_item(ldl_pkg::OP_PUSH, 8'h00, 1'b0, 1'b0);
    send_item(ldl_pkg::OP_PUSH, 8'hFF, 1'b1, 1'b1);
    send_item(ldl_pkg::OP_PUSH, 8'hA5, 1'b1, 1'b0);
    send_item(ldl_pkg::OP_PUSH, 8'h5A, 1'b0, 1'b1);
    // flush mid-frame drops the partial frame; its data is ignored
    send_item(ldl_pkg::OP_FLUSH, 8'hFF, 1'b1, 1'b1);
    send_item(ldl_pkg::OP_PUSH, 8'h80, 1'b0, 1'b0);
    send_item(ldl_pkg::OP_PUSH, 8'h01, 1'b1, 1'b1);
    send_item(ldl_pkg::OP_FLUSH, 8'h00, 1'b0, 1'b0);
    send_item(ldl_pkg::OP_FLUSH, 8'h3C, 1'b1, 1'b0);

    // Deep rings: all-ones registers clamp to full depth, lane 8 just above the
    // ceiling, lane 9 at it, lane 16 pass-through, lane 17 one frame
    regs_b        = {$urandom, $urandom};
    regs_b[15:0]  = 16'h8081;
    regs_c        = {$urandom, $urandom};
    regs_c[15:0]  = 16'h0100;
    drain_block();
    program_delays('1, regs_b, regs_c, '1);
    send_flush();
    // a few frames into the rings; no lane byte is due yet
    for (k = 0; k < DEEP_FRAMES * ldl_pkg::LANES; k++) send_push();

    // Shrink the delays mid-stream without a flush: heads past the end restart
    drain_block();
    program_delays(random_delays(0, 1'b0), random_delays(8, 1'b0),
                   random_delays(16, 1'b0), random_delays(24, 1'b0));
    for (k = 0; k < 3 * ldl_pkg::LANES; k++) send_push();
    send_flush();

    // Random phases; the first one runs pass-through under a long receiver hold-off
    base_items = sb.items_seen;
    phase      = 0;
    while (sb.items_seen - base_items < RANDOM_ITEMS) begin
      random_phase(phase % 5 == 0, $urandom_range(0, 4) != 0, phase == 0);
      phase++;
    end

    // Wind down
    @(negedge clk);
    in_tvalid <= 1'b0;
    for (k = 0; k < 4000 && sb.owed_bytes.size() != 0; k++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.owed_bytes.size() != 0) begin
      $error("%0d lane bytes never came out", sb.owed_bytes.size());
      sb.mismatches += sb.owed_bytes.size();
    end
    $display("Sent %0d items (%0d flushes) over %0d random phases; %0d register writes.",
             sb.items_seen, sb.flushes_seen, phase, sb.reg_writes);
    $display("Checked %0d lane bytes, with delay settings from pass-through to clamped %0d.",
             sb.bytes_checked, ldl_pkg::MAX_DELAY);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #10ms;
    $display("Timed out with %0d lane bytes still owed", sb.owed_bytes.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
